FILE: rtl/bmhq_pkg.sv
package bmhq_pkg;

   // Store geometry: the heap is cut into levels, level k holding slots 2^k-1 .. 2^(k+1)-2.
   localparam int HEAP_DEPTH = 256;
   localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
   localparam int LEVELS     = CNT_W;
   localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int POS_W      = LEVELS - 1;
   localparam int GIDX_W     = LEVELS + 1;

   // Request and status codes.
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      DIR_UP,
      DIR_DOWN
   } dir_type;

   typedef enum logic [1:0] {
      CELL_IDLE,
      CELL_READ,
      CELL_DECIDE
   } cell_state_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_LAST,
      TOP_RUN,
      TOP_DONE
   } top_state_type;

   // One stored entry: priority in the upper half, payload in the lower half.
   typedef struct packed {
      logic signed [31:0] pri;
      logic [31:0]        val;
   } entry_type;

   // The moving hole of a sift, handed from cell to cell.
   typedef struct packed {
      logic             valid;
      dir_type          dir;
      logic [POS_W-1:0] pos;
      entry_type        ent;
   } token_type;

   // Read request that a cell places on a neighbouring level.
   typedef struct packed {
      logic             valid;
      logic             to_parent;
      logic [POS_W-1:0] addr_a;
      logic [POS_W-1:0] addr_b;
   } rd_req_type;

   // Write into a cell's own level.
   typedef struct packed {
      logic             en;
      logic [POS_W-1:0] addr;
      entry_type        data;
   } wr_req_type;

   // Number of slots that level k really needs.
   function automatic int lvl_depth(input int k);
      int full_w;
      int rest;
      full_w = 1 << k;
      rest   = HEAP_DEPTH + 1 - full_w;
      return (full_w < rest) ? full_w : rest;
   endfunction

   // Level of a flat slot index: the position of the highest set bit of (index plus one).
   function automatic logic [LVL_W-1:0] idx_level(input logic [CNT_W-1:0] idx);
      logic [CNT_W-1:0] idx1;
      logic [LVL_W-1:0] lvl;
      idx1 = idx + CNT_W'(1);
      lvl  = '0;
      for (int i = 0; i < CNT_W; i++) begin
         if (idx1[i]) begin
            lvl = LVL_W'(i);
         end
      end
      return lvl;
   endfunction

   // Position of a flat slot index inside its level.
   function automatic logic [POS_W-1:0] idx_local(input logic [CNT_W-1:0] idx);
      logic [CNT_W-1:0] idx1;
      logic [CNT_W-1:0] rest;
      idx1 = idx + CNT_W'(1);
      rest = idx1 & ~(CNT_W'(1) << idx_level(idx));
      return rest[POS_W-1:0];
   endfunction

   // Ordering: lower signed priority is served first.
   function automatic logic key_less(input entry_type a, input entry_type b);
      return $signed(a.pri) < $signed(b.pri);
   endfunction

endpackage

FILE: rtl/bmhq_req_if.sv
interface bmhq_req_if;

   logic               valid;
   logic               ready;
   logic               req_type;
   logic [31:0]        entry_value;
   logic signed [31:0] entry_priority;

   modport source (output valid, output req_type, output entry_value,
                   output entry_priority, input ready);
   modport sink (input valid, input req_type, input entry_value,
                 input entry_priority, output ready);

endinterface

FILE: rtl/bmhq_rsp_if.sv
interface bmhq_rsp_if;

   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic [31:0]                 removed_value;
   logic signed [31:0]          removed_priority;
   logic [31:0]                 head_value;
   logic signed [31:0]          head_priority;
   logic                        is_empty;
   logic [bmhq_pkg::CNT_W-1:0]  entry_count;

   modport source (output valid, output status, output removed_value,
                   output removed_priority, output head_value, output head_priority,
                   output is_empty, output entry_count, input ready);
   modport sink (input valid, input status, input removed_value,
                 input removed_priority, input head_value, input head_priority,
                 input is_empty, input entry_count, output ready);

endinterface

FILE: rtl/bmhq_ram.sv
module bmhq_ram #(
   parameter int DEPTH  = 2,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [DEPTH];

   // One write port and two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

FILE: rtl/bmhq_cell.sv
module bmhq_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [bmhq_pkg::LVL_W-1:0]  lvl,
   input  logic [bmhq_pkg::CNT_W-1:0]  count,
   input  bmhq_pkg::token_type         tok_arrive,
   input  bmhq_pkg::entry_type         up_rd,
   input  bmhq_pkg::entry_type         dn_rd_a,
   input  bmhq_pkg::entry_type         dn_rd_b,
   output bmhq_pkg::token_type         tok_pass,
   output bmhq_pkg::rd_req_type        rd_req,
   output bmhq_pkg::wr_req_type        wr_req,
   output logic                        finish
);

   bmhq_pkg::cell_state_type state_ff, state_in;
   bmhq_pkg::token_type      tok_ff, tok_in;

   logic [bmhq_pkg::GIDX_W-1:0] base_g;
   logic [bmhq_pkg::GIDX_W-1:0] left_g;
   logic [bmhq_pkg::GIDX_W-1:0] right_g;
   logic [bmhq_pkg::POS_W-1:0]  child_a;
   logic [bmhq_pkg::POS_W-1:0]  child_b;
   logic [bmhq_pkg::POS_W-1:0]  parent_pos;
   logic                        has_left;
   logic                        has_right;
   logic                        pick_right;
   bmhq_pkg::entry_type         pick;
   logic                        promote;
   logic                        is_root;

   // Control state of the cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmhq_pkg::CELL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The token held while this level is worked on.
   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

   always_comb begin
      tok_in = tok_ff;
      if (state_ff == bmhq_pkg::CELL_IDLE && tok_arrive.valid) begin
         tok_in = tok_arrive;
      end
   end

   // Next state: read the neighbour level, then decide and write.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bmhq_pkg::CELL_IDLE: begin
            if (tok_arrive.valid) begin
               state_in = bmhq_pkg::CELL_READ;
            end
         end
         bmhq_pkg::CELL_READ:   state_in = bmhq_pkg::CELL_DECIDE;
         bmhq_pkg::CELL_DECIDE: state_in = bmhq_pkg::CELL_IDLE;
         default:               state_in = bmhq_pkg::CELL_IDLE;
      endcase
   end

   // Slot arithmetic and the comparison for this level.
   always_comb begin
      base_g     = (bmhq_pkg::GIDX_W'(1) << ({1'b0, lvl} + (bmhq_pkg::LVL_W + 1)'(1)))
                   - bmhq_pkg::GIDX_W'(1);
      left_g     = base_g + bmhq_pkg::GIDX_W'({tok_ff.pos, 1'b0});
      right_g    = left_g + bmhq_pkg::GIDX_W'(1);
      child_a    = bmhq_pkg::POS_W'({tok_ff.pos, 1'b0});
      child_b    = child_a | bmhq_pkg::POS_W'(1);
      parent_pos = tok_ff.pos >> 1;
      has_left   = left_g < bmhq_pkg::GIDX_W'(count);
      has_right  = right_g < bmhq_pkg::GIDX_W'(count);
      pick_right = has_right && bmhq_pkg::key_less(dn_rd_b, dn_rd_a);
      pick       = pick_right ? dn_rd_b : dn_rd_a;
      is_root    = (lvl == '0);
      if (tok_ff.dir == bmhq_pkg::DIR_DOWN) begin
         promote = has_left && bmhq_pkg::key_less(pick, tok_ff.ent);
      end else begin
         promote = !is_root && bmhq_pkg::key_less(tok_ff.ent, up_rd);
      end
   end

   // Outputs: read requests, the write into this level and the token hand-off.
   always_comb begin
      rd_req   = '0;
      wr_req   = '0;
      tok_pass = '0;
      finish   = 1'b0;
      case (state_ff)
         bmhq_pkg::CELL_READ: begin
            if (tok_ff.dir == bmhq_pkg::DIR_UP) begin
               rd_req.valid     = !is_root;
               rd_req.to_parent = 1'b1;
               rd_req.addr_a    = parent_pos;
            end else begin
               rd_req.valid     = 1'b1;
               rd_req.to_parent = 1'b0;
               rd_req.addr_a    = child_a;
               rd_req.addr_b    = child_b;
            end
         end
         bmhq_pkg::CELL_DECIDE: begin
            wr_req.en   = 1'b1;
            wr_req.addr = tok_ff.pos;
            if (promote) begin
               tok_pass.valid = 1'b1;
               tok_pass.dir   = tok_ff.dir;
               tok_pass.ent   = tok_ff.ent;
               if (tok_ff.dir == bmhq_pkg::DIR_DOWN) begin
                  wr_req.data  = pick;
                  tok_pass.pos = pick_right ? child_b : child_a;
               end else begin
                  wr_req.data  = up_rd;
                  tok_pass.pos = parent_pos;
               end
            end else begin
               wr_req.data = tok_ff.ent;
               finish      = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/binary_min_heap_queue_unit.sv
// Channel   Port       Direction  Transaction
// request   req_chan   sink       req_type, entry_value, entry_priority
// response  rsp_chan   source     status, removed and head entries, is_empty, entry_count
//
// Each heap level lives in its own cell with its own memory; a sift is a token that walks
// the row of cells, each cell reading the neighbour level, then comparing and writing; it
// visits at most nine levels. A remove that leaves entries first fetches the last slot;
// refused transactions and the removal of the only entry start no sift. One transaction is
// worked on at a time, and a held response does not stop the next request from being
// taken. Reset empties the heap at once.
module binary_min_heap_queue_unit (
   input logic         clock,
   input logic         reset,
   bmhq_req_if.sink    req_chan,
   bmhq_rsp_if.source  rsp_chan
);

   localparam int L = bmhq_pkg::LEVELS;

   bmhq_pkg::top_state_type     state_ff, state_in;
   logic [bmhq_pkg::CNT_W-1:0]  size_ff, size_in;
   logic [bmhq_pkg::LVL_W-1:0]  last_lvl_ff;
   bmhq_pkg::status_type        status_ff;
   bmhq_pkg::entry_type         rem_ff;
   bmhq_pkg::entry_type         head_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   bmhq_pkg::status_type        rsp_status_ff;
   bmhq_pkg::entry_type         rsp_rem_ff;
   bmhq_pkg::entry_type         rsp_head_ff;
   logic                        rsp_empty_ff;
   logic [bmhq_pkg::CNT_W-1:0]  rsp_count_ff;

   logic                        accept;
   logic                        rsp_load;
   logic                        any_finish;
   logic [bmhq_pkg::CNT_W-1:0]  last_idx;
   logic [bmhq_pkg::POS_W-1:0]  last_pos;
   bmhq_pkg::token_type         start_tok;
   logic [bmhq_pkg::LVL_W-1:0]  start_lvl;
   bmhq_pkg::entry_type         new_ent;

   bmhq_pkg::token_type         cell_tok_out [L];
   bmhq_pkg::rd_req_type        cell_rd      [L];
   bmhq_pkg::wr_req_type        cell_wr      [L];
   bmhq_pkg::entry_type         ram_a        [L];
   bmhq_pkg::entry_type         ram_b        [L];
   logic [L-1:0]                cell_fin;

   assign accept     = req_chan.valid && req_chan.ready;
   assign any_finish = |cell_fin;
   assign last_idx   = size_ff - bmhq_pkg::CNT_W'(1);
   assign last_pos   = bmhq_pkg::idx_local(last_idx);
   assign new_ent    = '{pri: req_chan.entry_priority, val: req_chan.entry_value};

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmhq_pkg::TOP_IDLE;
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bmhq_pkg::TOP_IDLE: begin
            if (accept) begin
               if (req_chan.req_type == bmhq_pkg::REQ_INSERT) begin
                  if (size_ff >= bmhq_pkg::CNT_W'(bmhq_pkg::HEAP_DEPTH)) begin
                     state_in = bmhq_pkg::TOP_DONE;
                  end else begin
                     state_in = bmhq_pkg::TOP_RUN;
                  end
               end else begin
                  if (size_ff <= bmhq_pkg::CNT_W'(1)) begin
                     state_in = bmhq_pkg::TOP_DONE;
                  end else begin
                     state_in = bmhq_pkg::TOP_LAST;
                  end
               end
            end
         end
         bmhq_pkg::TOP_LAST: state_in = bmhq_pkg::TOP_RUN;
         bmhq_pkg::TOP_RUN: begin
            if (any_finish) begin
               state_in = bmhq_pkg::TOP_DONE;
            end
         end
         bmhq_pkg::TOP_DONE: begin
            if (rsp_load) begin
               state_in = bmhq_pkg::TOP_IDLE;
            end
         end
         default: state_in = bmhq_pkg::TOP_IDLE;
      endcase
   end

   // Sequencer outputs: handshake, entry count, sift start and response load.
   always_comb begin
      req_chan.ready = (state_ff == bmhq_pkg::TOP_IDLE);
      rsp_load       = 1'b0;
      start_tok      = '0;
      start_lvl      = '0;
      size_in        = size_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         bmhq_pkg::TOP_IDLE: begin
            if (accept) begin
               if (req_chan.req_type == bmhq_pkg::REQ_INSERT) begin
                  if (size_ff < bmhq_pkg::CNT_W'(bmhq_pkg::HEAP_DEPTH)) begin
                     size_in       = size_ff + bmhq_pkg::CNT_W'(1);
                     start_tok.valid = 1'b1;
                     start_tok.dir = bmhq_pkg::DIR_UP;
                     start_tok.pos = bmhq_pkg::idx_local(size_ff);
                     start_tok.ent = new_ent;
                     start_lvl     = bmhq_pkg::idx_level(size_ff);
                  end
               end else if (size_ff != '0) begin
                  size_in = last_idx;
               end
            end
         end
         bmhq_pkg::TOP_LAST: begin
            start_tok.valid = 1'b1;
            start_tok.dir   = bmhq_pkg::DIR_DOWN;
            start_tok.pos   = '0;
            start_tok.ent   = ram_a[last_lvl_ff];
            start_lvl       = '0;
         end
         bmhq_pkg::TOP_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Per-transaction data: status, removed entry and the level of the last slot.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff   <= bmhq_pkg::ST_OK;
         rem_ff      <= '0;
         last_lvl_ff <= bmhq_pkg::idx_level(last_idx);
         if (req_chan.req_type == bmhq_pkg::REQ_INSERT) begin
            if (size_ff >= bmhq_pkg::CNT_W'(bmhq_pkg::HEAP_DEPTH)) begin
               status_ff <= bmhq_pkg::ST_FULL;
            end
         end else if (size_ff == '0) begin
            status_ff <= bmhq_pkg::ST_EMPTY;
         end else begin
            rem_ff <= head_ff;
         end
      end
   end

   // Copy of the root, kept up to date from the writes into the top level.
   always_ff @(posedge clock) begin
      if (cell_wr[0].en) begin
         head_ff <= cell_wr[0].data;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_rem_ff    <= rem_ff;
         rsp_head_ff   <= (size_ff == '0) ? '0 : head_ff;
         rsp_empty_ff  <= (size_ff == '0);
         rsp_count_ff  <= size_ff;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.removed_value    = rsp_rem_ff.val;
   assign rsp_chan.removed_priority = rsp_rem_ff.pri;
   assign rsp_chan.head_value       = rsp_head_ff.val;
   assign rsp_chan.head_priority    = rsp_head_ff.pri;
   assign rsp_chan.is_empty         = rsp_empty_ff;
   assign rsp_chan.entry_count      = rsp_count_ff;

   // The row of cells, one per heap level, each with its own memory.
   for (genvar k = 0; k < L; k++) begin : g_level
      localparam int DEP = bmhq_pkg::lvl_depth(k);
      localparam int AW  = (DEP > 1) ? $clog2(DEP) : 1;

      bmhq_pkg::token_type        tok_above, tok_below, tok_arrive;
      bmhq_pkg::rd_req_type       rd_above, rd_below;
      bmhq_pkg::entry_type        up_rd, dn_rd_a, dn_rd_b;
      bmhq_pkg::entry_type        rd_a, rd_b;
      logic [bmhq_pkg::POS_W-1:0] addr_a, addr_b;

      // Neighbour wiring: the first level has nothing above, the last nothing below.
      if (k > 0) begin : g_above
         assign tok_above = cell_tok_out[k-1];
         assign rd_above  = cell_rd[k-1];
         assign up_rd     = ram_a[k-1];
      end else begin : g_no_above
         assign tok_above = '0;
         assign rd_above  = '0;
         assign up_rd     = '0;
      end

      if (k < L - 1) begin : g_below
         assign tok_below = cell_tok_out[k+1];
         assign rd_below  = cell_rd[k+1];
         assign dn_rd_a   = ram_a[k+1];
         assign dn_rd_b   = ram_b[k+1];
      end else begin : g_no_below
         assign tok_below = '0;
         assign rd_below  = '0;
         assign dn_rd_a   = '0;
         assign dn_rd_b   = '0;
      end

      // Token arriving at this level: a new sift, or one handed on by a neighbour.
      always_comb begin
         tok_arrive = '0;
         if (start_tok.valid && start_lvl == bmhq_pkg::LVL_W'(k)) begin
            tok_arrive = start_tok;
         end else if (tok_above.valid && tok_above.dir == bmhq_pkg::DIR_DOWN) begin
            tok_arrive = tok_above;
         end else if (tok_below.valid && tok_below.dir == bmhq_pkg::DIR_UP) begin
            tok_arrive = tok_below;
         end
      end

      // Read addresses: a parent read from below, a child pair from above,
      // otherwise the last slot for a remove.
      always_comb begin
         addr_a = last_pos;
         addr_b = '0;
         if (rd_below.valid && rd_below.to_parent) begin
            addr_a = rd_below.addr_a;
         end else if (rd_above.valid && !rd_above.to_parent) begin
            addr_a = rd_above.addr_a;
            addr_b = rd_above.addr_b;
         end
      end

      assign ram_a[k] = rd_a;
      assign ram_b[k] = rd_b;

      bmhq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .lvl        (bmhq_pkg::LVL_W'(k)),
         .count      (size_ff),
         .tok_arrive (tok_arrive),
         .up_rd      (up_rd),
         .dn_rd_a    (dn_rd_a),
         .dn_rd_b    (dn_rd_b),
         .tok_pass   (cell_tok_out[k]),
         .rd_req     (cell_rd[k]),
         .wr_req     (cell_wr[k]),
         .finish     (cell_fin[k])
      );

      bmhq_ram #(
         .DEPTH  (DEP),
         .ADDR_W (AW),
         .DATA_W ($bits(bmhq_pkg::entry_type))
      ) u_ram (
         .clock     (clock),
         .wr_en     (cell_wr[k].en),
         .wr_addr   (cell_wr[k].addr[AW-1:0]),
         .wr_data   (cell_wr[k].data),
         .rd_addr_a (addr_a[AW-1:0]),
         .rd_addr_b (addr_b[AW-1:0]),
         .rd_data_a (rd_a),
         .rd_data_b (rd_b)
      );
   end

endmodule

FILE: tb/tb_binary_min_heap_queue_unit.sv
module tb_binary_min_heap_queue_unit;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_ITEMS  = 1700;
   localparam int HOLD_CYCLES   = 400;
   localparam int TAIL_CYCLES   = 40;

   // One request transaction as the generator plans it.
   typedef struct {
      logic               kind;
      logic [31:0]        value;
      logic signed [31:0] prio;
   } heap_op_type;

   // The response that a request transaction should produce.
   typedef struct {
      bmhq_pkg::status_type         status;
      logic [31:0]                  rem_value;
      logic signed [31:0]           rem_prio;
      logic [31:0]                  head_value;
      logic signed [31:0]           head_prio;
      logic                         empty;
      logic [bmhq_pkg::CNT_W-1:0]   count;
   } heap_outcome_type;

   logic clock = 1'b0;
   logic reset;

   bmhq_req_if req_if ();
   bmhq_rsp_if rsp_if ();

   binary_min_heap_queue_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #1 clock = ~clock;

   // Shadow heap kept in step with the accepted requests.
   bmhq_pkg::entry_type heap_slots [bmhq_pkg::HEAP_DEPTH];
   int unsigned         heap_fill = 0;

   heap_op_type      queued_ops [$];
   heap_outcome_type heap_op_outcomes [$];
   heap_op_type      live_op;

   int unsigned   op_total   = 0;
   int unsigned   ops_taken  = 0;
   int unsigned   plan_depth = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count = 0;
   int unsigned   hold_left = 0;
   logic          hold_done = 1'b0;

   // Applies one request to the shadow heap and returns the response it should give.
   function automatic heap_outcome_type heap_apply(heap_op_type op);
      heap_outcome_type    res;
      int unsigned         i;
      int unsigned         up;
      int unsigned         lchild;
      int unsigned         rchild;
      int unsigned         pick;
      bmhq_pkg::entry_type tmp;
      logic                settled;
      res.status     = bmhq_pkg::ST_OK;
      res.rem_value  = '0;
      res.rem_prio   = '0;
      res.head_value = '0;
      res.head_prio  = '0;
      if (op.kind == bmhq_pkg::REQ_INSERT) begin
         if (heap_fill >= bmhq_pkg::HEAP_DEPTH) begin
            res.status = bmhq_pkg::ST_FULL;
         end else begin
            heap_slots[heap_fill].pri = op.prio;
            heap_slots[heap_fill].val = op.value;
            i = heap_fill;
            heap_fill++;
            // Sift up while strictly below the parent.
            settled = 1'b0;
            while (i != 0 && !settled) begin
               up = (i - 1) / 2;
               if ($signed(heap_slots[i].pri) < $signed(heap_slots[up].pri)) begin
                  tmp = heap_slots[i];
                  heap_slots[i] = heap_slots[up];
                  heap_slots[up] = tmp;
                  i = up;
               end else begin
                  settled = 1'b1;
               end
            end
         end
      end else begin
         if (heap_fill == 0) begin
            res.status = bmhq_pkg::ST_EMPTY;
         end else begin
            res.rem_value = heap_slots[0].val;
            res.rem_prio  = heap_slots[0].pri;
            heap_fill--;
            heap_slots[0] = heap_slots[heap_fill];
            // Sift down, taking the left child when the two children tie.
            i = 0;
            settled = 1'b0;
            while (!settled) begin
               lchild = 2 * i + 1;
               rchild = lchild + 1;
               if (lchild >= heap_fill) begin
                  settled = 1'b1;
               end else begin
                  pick = lchild;
                  if (rchild < heap_fill &&
                      $signed(heap_slots[rchild].pri) < $signed(heap_slots[lchild].pri)) begin
                     pick = rchild;
                  end
                  if ($signed(heap_slots[i].pri) > $signed(heap_slots[pick].pri)) begin
                     tmp = heap_slots[i];
                     heap_slots[i] = heap_slots[pick];
                     heap_slots[pick] = tmp;
                     i = pick;
                  end else begin
                     settled = 1'b1;
                  end
               end
            end
         end
      end
      if (heap_fill != 0) begin
         res.head_value = heap_slots[0].val;
         res.head_prio  = heap_slots[0].pri;
      end
      res.empty = (heap_fill == 0);
      res.count = bmhq_pkg::CNT_W'(heap_fill);
      return res;
   endfunction

   // Priorities lean towards ties and the ends of the signed range.
   function automatic logic signed [31:0] pick_priority();
      case ($urandom_range(0, 7))
         0, 1:    return $urandom;
         2, 3:    return 32'(int'($urandom_range(0, 6)) - 3);
         4: begin
            case ($urandom_range(0, 3))
               0:       return 32'sh8000_0000;
               1:       return 32'sh7FFF_FFFF;
               2:       return 32'sh0000_0000;
               default: return 32'shFFFF_FFFF;
            endcase
         end
         default: return 32'(int'($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return 32'hFFFF_FFFF;
         1:       return 32'h0000_0000;
         2:       return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   // Queues a request and keeps track of the depth the heap will have.
   function automatic void queue_fixed(logic kind, logic [31:0] value, logic signed [31:0] prio);
      heap_op_type op;
      op.kind  = kind;
      op.value = value;
      op.prio  = prio;
      queued_ops.push_back(op);
      if (kind == bmhq_pkg::REQ_INSERT) begin
         if (plan_depth < bmhq_pkg::HEAP_DEPTH) begin
            plan_depth++;
         end
      end else if (plan_depth != 0) begin
         plan_depth--;
      end
   endfunction

   function automatic void queue_op(logic kind);
      queue_fixed(kind, pick_value(), pick_priority());
   endfunction

   function automatic void queue_fill_overflow();
      while (plan_depth < bmhq_pkg::HEAP_DEPTH) begin
         queue_op(bmhq_pkg::REQ_INSERT);
      end
      repeat ($urandom_range(2, 4)) queue_op(bmhq_pkg::REQ_INSERT);
   endfunction

   function automatic void queue_drain_underflow();
      while (plan_depth != 0) begin
         queue_op(bmhq_pkg::REQ_REMOVE);
      end
      repeat ($urandom_range(1, 3)) queue_op(bmhq_pkg::REQ_REMOVE);
   endfunction

   // Idling percentages for the three phases of the run.
   function automatic int send_idle_pct();
      case ((ops_taken * 3) / op_total)
         0:       return 16;
         1:       return 46;
         default: return 0;
      endcase
   endfunction

   function automatic int recv_idle_pct();
      case ((ops_taken * 3) / op_total)
         0:       return 46;
         1:       return 16;
         default: return 0;
      endcase
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("response %0d: %s got %h, wanted %h", ops_taken, field, got, want);
      mismatch_count++;
   endtask

   // Stimulus plan, reset and the end of the run.
   initial begin
      int unsigned seg;
      int unsigned len;
      int unsigned ins_pct;
      reset = 1'b1;

      // Directed part: refused remove, range extremes, ties and a drain past empty.
      queue_fixed(bmhq_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 32'sh8000_0000);
      queue_fixed(bmhq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
      queue_fixed(bmhq_pkg::REQ_INSERT, 32'h0000_0000, 32'sh8000_0000);
      queue_fixed(bmhq_pkg::REQ_INSERT, 32'h0000_0001, 32'sh0000_0000);
      queue_fixed(bmhq_pkg::REQ_INSERT, 32'h0000_0002, 32'sh0000_0000);
      queue_fixed(bmhq_pkg::REQ_INSERT, 32'h0000_0003, 32'shFFFF_FFFF);
      queue_fixed(bmhq_pkg::REQ_INSERT, 32'h0000_0004, 32'sh0000_0000);
      queue_fixed(bmhq_pkg::REQ_INSERT, 32'hA5A5_A5A5, 32'sh8000_0000);
      repeat (7) queue_fixed(bmhq_pkg::REQ_REMOVE, 32'h5A5A_5A5A, 32'sh7FFF_FFFF);
      queue_fixed(bmhq_pkg::REQ_REMOVE, 32'h0000_0000, 32'sh0000_0000);
      op_total = queued_ops.size();

      // Random part: one full fill and drain, then mixed stretches.
      queue_fill_overflow();
      queue_drain_underflow();
      while (queued_ops.size() < op_total + RANDOM_ITEMS) begin
         seg = $urandom_range(0, 9);
         len = $urandom_range(10, 70);
         if (seg == 0) begin
            queue_fill_overflow();
         end else if (seg == 1) begin
            queue_drain_underflow();
         end else begin
            ins_pct = (seg < 5) ? 80 : (seg < 8) ? 25 : 55;
            repeat (len) queue_op(($urandom_range(0, 99) < ins_pct) ?
                                  bmhq_pkg::REQ_INSERT : bmhq_pkg::REQ_REMOVE);
         end
      end
      op_total = queued_ops.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (ops_taken < op_total) @(posedge clock);
      while (heap_op_outcomes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("binary_min_heap_queue_unit: match");
      end else begin
         $display("binary_min_heap_queue_unit: mismatch");
      end
      $finish;
   end

   // Request driver: predicts each accepted transaction and offers the next one.
   always @(posedge clock) begin
      logic fired;
      if (reset) begin
         req_if.valid          <= 1'b0;
         req_if.req_type       <= bmhq_pkg::REQ_INSERT;
         req_if.entry_value    <= '0;
         req_if.entry_priority <= '0;
      end else begin
         fired = req_if.valid && req_if.ready;
         if (fired) begin
            heap_op_outcomes.push_back(heap_apply(live_op));
            ops_taken++;
         end
         if (fired || !req_if.valid) begin
            if (queued_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
               live_op = queued_ops.pop_front();
               req_if.valid          <= 1'b1;
               req_if.req_type       <= live_op.kind;
               req_if.entry_value    <= live_op.value;
               req_if.entry_priority <= live_op.prio;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response ready, with one long hold-off late in the run to back the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_if.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && ops_taken >= (op_total * 3) / 4) begin
         rsp_if.ready <= 1'b0;
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct());
      end
   end

   // Response monitor: each transaction is checked against the oldest prediction.
   always @(posedge clock) begin
      heap_outcome_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (heap_op_outcomes.size() == 0) begin
            report_mismatch("unexpected response", 64'(rsp_if.status), 64'd0);
         end else begin
            want = heap_op_outcomes.pop_front();
            if (rsp_if.status !== want.status)
               report_mismatch("status", 64'(rsp_if.status), 64'(want.status));
            if (rsp_if.removed_value !== want.rem_value)
               report_mismatch("removed_value", 64'(rsp_if.removed_value), 64'(want.rem_value));
            if (rsp_if.removed_priority !== want.rem_prio)
               report_mismatch("removed_priority", 64'(rsp_if.removed_priority),
                               64'(want.rem_prio));
            if (rsp_if.head_value !== want.head_value)
               report_mismatch("head_value", 64'(rsp_if.head_value), 64'(want.head_value));
            if (rsp_if.head_priority !== want.head_prio)
               report_mismatch("head_priority", 64'(rsp_if.head_priority), 64'(want.head_prio));
            if (rsp_if.is_empty !== want.empty)
               report_mismatch("is_empty", 64'(rsp_if.is_empty), 64'(want.empty));
            if (rsp_if.entry_count !== want.count)
               report_mismatch("entry_count", 64'(rsp_if.entry_count), 64'(want.count));
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("binary_min_heap_queue_unit: mismatch");
         $finish;
      end
   end

endmodule
